### rtl/core/stvm_pkg.sv
package stvm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EPS_FACTOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_UP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DOWN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_MARGIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RT_DELTA    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RT_PERIOD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd7;

  // item kinds
  localparam logic FUNC_MEAS = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  // register reset values
  localparam logic [7:0]  EPS_FACTOR_RST  = 8'd73;
  localparam logic [14:0] MAX_TORQUE_RST  = 15'd1500;
  localparam logic [14:0] RATE_UP_RST     = 15'd15;
  localparam logic [14:0] RATE_DOWN_RST   = 15'd25;
  localparam logic [14:0] ERR_MARGIN_RST  = 15'd350;
  localparam logic [14:0] RT_DELTA_RST    = 15'd450;
  localparam logic [31:0] RT_PERIOD_RST   = 32'd250000;
  localparam logic [31:0] TIME_STEP_RST   = 32'd10000;

  // scaled sample, window bounds and check arithmetic
  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned BOUND_W  = 19;
  localparam int unsigned CALC_W   = 20;
  localparam int unsigned PROD_W   = 25;
  localparam int unsigned MAG_W    = 23;

  // divide by 100: exact for magnitudes below 2^23
  localparam int unsigned RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;
  localparam int unsigned DIV_SHIFT = 30;

  typedef logic signed [SAMPLE_W-1:0] scaled_t;
  typedef logic signed [BOUND_W-1:0]  bound_t;
  typedef logic signed [CALC_W-1:0]   calc_t;

  typedef struct packed {
    logic               func;
    logic [15:0]        measured_raw;
    logic signed [15:0] cmd_torque;
    logic               ctrl_allowed;
  } item_t;

  typedef struct packed {
    logic violation;
    logic over_limit;
    logic rate_fail;
    logic realtime_fail;
  } result_t;

endpackage

### rtl/core/stvm_if.sv
interface stvm_item_if;
  logic            valid;
  logic            ready;
  stvm_pkg::item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface stvm_result_if;
  logic              valid;
  logic              ready;
  stvm_pkg::result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/steer_torque_violation_monitor.sv
// Path: a command beat passes the input register, the scale multiply and the
// divide-by-100 multiply registers, then the checks into the result register.
// Throughput: one beat per cycle unless stalled; measurement beats produce no result.
// The pipeline stalls only when the result register is full and not taken.
// Reset (synchronous): registers return to defaults, window and history clear.
module steer_torque_violation_monitor #(
  parameter int unsigned WINDOW_DEPTH = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [stvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stvm_pkg::CFG_DATA_W-1:0]  cfg_data,
  stvm_item_if.sink                        item,
  stvm_result_if.source                    result
);
  import stvm_pkg::*;

  localparam int unsigned TREE_LEVELS = $clog2(WINDOW_DEPTH);
  localparam int unsigned TREE_SPAN   = 1 << TREE_LEVELS;
  localparam int unsigned QUO_W       = MAG_W + RECIP_W;

  function automatic calc_t cmin(input calc_t a, input calc_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic calc_t cmax(input calc_t a, input calc_t b);
    return (a > b) ? a : b;
  endfunction

  // configuration
  logic [7:0]  eps_factor;
  logic [14:0] max_torque;
  logic [14:0] rate_up;
  logic [14:0] rate_down;
  logic [14:0] err_margin;
  logic [14:0] rt_delta;
  logic [31:0] rt_period;
  logic [31:0] time_step;

  // pipeline
  logic               s0_valid;
  item_t              s0_item;
  logic               s1_valid;
  logic               s1_func;
  logic signed [15:0] s1_desired;
  logic               s1_allowed;
  logic               s1_neg;
  logic [MAG_W-1:0]   s1_mag;
  logic               s2_valid;
  logic               s2_func;
  logic signed [15:0] s2_desired;
  logic               s2_allowed;
  scaled_t            s2_sample;
  logic               res_valid;
  result_t            res_data;

  // monitor state
  scaled_t            win [WINDOW_DEPTH];
  bound_t             meas_low;
  bound_t             meas_high;
  logic signed [15:0] last_command;
  logic signed [15:0] rt_reference;
  logic [31:0]        rt_elapsed;

  // flow control
  logic x_meas, x_cmd, out_free, s2_go, s2_open, s1_open, s0_open;

  assign x_meas   = s2_valid && (s2_func == FUNC_MEAS);
  assign x_cmd    = s2_valid && (s2_func == FUNC_CMD);
  assign out_free = !res_valid || result.ready;
  assign s2_go    = x_meas || (x_cmd && out_free);
  assign s2_open  = !s2_valid || s2_go;
  assign s1_open  = !s1_valid || s2_open;
  assign s0_open  = !s0_valid || s1_open;

  assign item.ready   = s0_open;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  // scale: signed raw times factor, kept as sign and magnitude
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_abs;

  always_comb begin
    prod     = PROD_W'(signed'(s0_item.measured_raw)) * PROD_W'(signed'({1'b0, eps_factor}));
    prod_abs = prod[PROD_W-1] ? -prod : prod;
  end

  // divide by 100 through the reciprocal, truncating toward zero
  logic [QUO_W-1:0]    quo_full;
  logic [SAMPLE_W-2:0] quo_mag;
  scaled_t             quo_signed;

  always_comb begin
    quo_full   = QUO_W'(s1_mag) * QUO_W'(DIV_RECIP);
    quo_mag    = quo_full[DIV_SHIFT +: SAMPLE_W-1];
    quo_signed = s1_neg ? -scaled_t'({1'b0, quo_mag}) : scaled_t'({1'b0, quo_mag});
  end

  // shifted window and its bounds through a min/max tree
  scaled_t win_shift [WINDOW_DEPTH];
  scaled_t lo_tree [TREE_SPAN];
  scaled_t hi_tree [TREE_SPAN];

  always_comb begin
    win_shift[0] = s2_sample;
    for (int k = 1; k < WINDOW_DEPTH; k++) begin
      win_shift[k] = win[k-1];
    end
    for (int i = 0; i < TREE_SPAN; i++) begin
      lo_tree[i] = win_shift[(i < WINDOW_DEPTH) ? i : 0];
      hi_tree[i] = win_shift[(i < WINDOW_DEPTH) ? i : 0];
    end
    for (int l = 0; l < TREE_LEVELS; l++) begin
      for (int i = 0; i < TREE_SPAN / 2; i++) begin
        if (i < (TREE_SPAN >> (l + 1))) begin
          lo_tree[i] = (lo_tree[2*i] < lo_tree[2*i+1]) ? lo_tree[2*i] : lo_tree[2*i+1];
          hi_tree[i] = (hi_tree[2*i] > hi_tree[2*i+1]) ? hi_tree[2*i] : hi_tree[2*i+1];
        end
      end
    end
  end

  // command checks
  calc_t       val, lc, rr, lim, hi_rl, lo_rl, hi_lim, lo_lim;
  logic        chk_over, chk_rate, chk_rt, viol, refresh;
  logic [31:0] elapsed_step;
  result_t     res_next;

  always_comb begin
    val    = calc_t'(s2_desired);
    lc     = calc_t'(last_command);
    rr     = calc_t'(rt_reference);
    lim    = calc_t'(max_torque);
    hi_rl  = cmax(lc, '0) + calc_t'(rate_up);
    lo_rl  = cmin(lc, '0) - calc_t'(rate_up);
    hi_lim = cmin(hi_rl, cmax(lc - calc_t'(rate_down),
                              cmax(calc_t'(meas_high), '0) + calc_t'(err_margin)));
    lo_lim = cmax(lo_rl, cmin(lc + calc_t'(rate_down),
                              cmin(calc_t'(meas_low), '0) - calc_t'(err_margin)));

    chk_over = (val > lim) || (val < -lim);
    chk_rate = (val < lo_lim) || (val > hi_lim);
    chk_rt   = (val < cmin(rr, '0) - calc_t'(rt_delta)) ||
               (val > cmax(rr, '0) + calc_t'(rt_delta));

    elapsed_step = rt_elapsed + time_step;
    refresh      = elapsed_step > rt_period;

    if (s2_allowed) begin
      viol     = chk_over || chk_rate || chk_rt;
      res_next = '{violation: viol, over_limit: chk_over,
                   rate_fail: chk_rate, realtime_fail: chk_rt};
    end else begin
      viol     = (s2_desired != '0);
      res_next = '{violation: viol, over_limit: 1'b0,
                   rate_fail: 1'b0, realtime_fail: 1'b0};
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_factor   <= EPS_FACTOR_RST;
      max_torque   <= MAX_TORQUE_RST;
      rate_up      <= RATE_UP_RST;
      rate_down    <= RATE_DOWN_RST;
      err_margin   <= ERR_MARGIN_RST;
      rt_delta     <= RT_DELTA_RST;
      rt_period    <= RT_PERIOD_RST;
      time_step    <= TIME_STEP_RST;
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      res_valid    <= 1'b0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        win[k] <= '0;
      end
      meas_low     <= '0;
      meas_high    <= '0;
      last_command <= '0;
      rt_reference <= '0;
      rt_elapsed   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EPS_FACTOR:  eps_factor  <= cfg_data[7:0];
          REG_MAX_TORQUE:  max_torque  <= cfg_data[14:0];
          REG_RATE_UP:     rate_up     <= cfg_data[14:0];
          REG_RATE_DOWN:   rate_down   <= cfg_data[14:0];
          REG_ERR_MARGIN:  err_margin  <= cfg_data[14:0];
          REG_RT_DELTA:    rt_delta    <= cfg_data[14:0];
          REG_RT_PERIOD:   rt_period   <= cfg_data;
          REG_TIME_STEP:   time_step   <= cfg_data;
        endcase
      end

      if (s0_open) s0_valid <= item.valid;
      if (s1_open) s1_valid <= s0_valid;
      if (s2_open) s2_valid <= s1_valid;

      if (s2_go && x_cmd) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (s2_go && x_meas) begin
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
          win[k] <= win_shift[k];
        end
        meas_low  <= bound_t'(lo_tree[0]) - bound_t'(1);
        meas_high <= bound_t'(hi_tree[0]) + bound_t'(1);
      end

      if (s2_go && x_cmd) begin
        if (s2_allowed && !viol) begin
          last_command <= s2_desired;
          if (refresh) begin
            rt_reference <= s2_desired;
            rt_elapsed   <= '0;
          end else begin
            rt_elapsed   <= elapsed_step;
          end
        end else begin
          // drop the history and restart the interval
          last_command <= '0;
          rt_reference <= '0;
          rt_elapsed   <= '0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s0_open) s0_item <= item.data;
    if (s1_open) begin
      s1_func    <= s0_item.func;
      s1_desired <= s0_item.cmd_torque;
      s1_allowed <= s0_item.ctrl_allowed;
      s1_neg     <= prod[PROD_W-1];
      s1_mag     <= prod_abs[MAG_W-1:0];
    end
    if (s2_open) begin
      s2_func    <= s1_func;
      s2_desired <= s1_desired;
      s2_allowed <= s1_allowed;
      s2_sample  <= quo_signed;
    end
    if (s2_go && x_cmd) res_data <= res_next;
  end

endmodule
